[hdl/greedy_box_suppression_core_defines.svh]
// Assertion macros used by the checker of the box suppression core
`ifndef GREEDY_BOX_SUPPRESSION_CORE_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_CORE_DEFINES_SVH

// Next-cycle implication, checked during reset as well
`define GBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define GBS_ASSERT_NEXT_RUN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gbs_pkg.sv]
// Shared constants and types of the box suppression core
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;
  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int SCORE_W        = 16;
  localparam int LABEL_W        = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int FIFO_DEPTH     = 4;
  localparam int OVL_LAT        = 4;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESORTED = 1'b1;
  localparam logic [SCORE_W-1:0]   THR_RESET     = 16'd29491;

  typedef struct packed {
    logic [SCORE_W-1:0] threshold;
    logic               presorted;
  } cfg_t;
endpackage
`default_nettype wire

[hdl/greedy_box_suppression_core.sv]
// Top level of the greedy box suppression core
//
//   channel   handshake            transfer when          payload
//   boxes in  push / full          push && !full          left_x .. final_box
//   kept out  empty / pop          pop && !empty          kept_left_x .. capacity_overflow
//   config    cfg_write            cfg_write              cfg_index, cfg_data
//
// Boxes load at one per cycle through a four-entry queue into the box store, while
// the back end is in its load state. Ranking, when it runs, compares each box with
// every box of the set through the single read port of the box store; suppression
// tests each kept box against every later box through the overlap pipeline; emission
// passes each kept box to the result register and skips suppressed ones, with any
// wait on pop. Once the queue has filled, full holds the input off until the back end loads again.
// rst is synchronous: it empties the queue, the set and the result register and
// restores the register defaults. A stalled result holds until popped.
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_suppression_core #(
  parameter int MAX_BOXES  = gbs_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [COORD_BITS-1:0]          left_x,
  input  wire logic [COORD_BITS-1:0]          top_y,
  input  wire logic [COORD_BITS-1:0]          right_x,
  input  wire logic [COORD_BITS-1:0]          bottom_y,
  input  wire logic [gbs_pkg::SCORE_W-1:0]    confidence,
  input  wire logic [gbs_pkg::LABEL_W-1:0]    label_id,
  input  wire logic                           final_box,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [COORD_BITS-1:0]               kept_left_x,
  output logic [COORD_BITS-1:0]               kept_top_y,
  output logic [COORD_BITS-1:0]               kept_right_x,
  output logic [COORD_BITS-1:0]               kept_bottom_y,
  output logic [gbs_pkg::SCORE_W-1:0]         kept_confidence,
  output logic [gbs_pkg::LABEL_W-1:0]         kept_label,
  output logic                                end_of_set,
  output logic                                capacity_overflow,
  input  wire logic                           cfg_write,
  input  wire logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int BOX_W = 4*COORD_BITS + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;

  gbs_pkg::cfg_t    cfg;
  logic             item_valid;
  logic             item_pop;
  logic [BOX_W-1:0] item_box;
  logic             item_final;
  logic             out_valid;

  // Configuration registers: the user must write them only while the core is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= gbs_pkg::THR_RESET;
      cfg.presorted <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        gbs_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data;
        gbs_pkg::REG_PRESORTED: cfg.presorted <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: queue incoming boxes so the input side can run ahead of the back end
  gbs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .left_x(left_x), .top_y(top_y), .right_x(right_x), .bottom_y(bottom_y),
    .confidence(confidence), .label_id(label_id), .final_box(final_box),
    .item_valid(item_valid), .item_pop(item_pop), .item_box(item_box),
    .item_final(item_final)
  );

  // Back: store, rank, suppress and emit; result register drives the output side
  gbs_back #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .item_valid(item_valid), .item_pop(item_pop), .item_box(item_box),
    .item_final(item_final),
    .out_valid(out_valid), .out_pop(pop && out_valid),
    .out_left(kept_left_x), .out_top(kept_top_y), .out_right(kept_right_x),
    .out_bottom(kept_bottom_y), .out_score(kept_confidence), .out_label(kept_label),
    .out_eos(end_of_set), .out_ovf(capacity_overflow)
  );

  assign empty = !out_valid;
endmodule
`default_nettype wire

[hdl/gbs_ram.sv]
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[hdl/gbs_front.sv]
// Front end: accepts boxes and queues them with their end-of-set mark
`timescale 1ns / 1ps
`default_nettype none
module gbs_front #(
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [COORD_BITS-1:0]       left_x,
  input  wire logic [COORD_BITS-1:0]       top_y,
  input  wire logic [COORD_BITS-1:0]       right_x,
  input  wire logic [COORD_BITS-1:0]       bottom_y,
  input  wire logic [gbs_pkg::SCORE_W-1:0] confidence,
  input  wire logic [gbs_pkg::LABEL_W-1:0] label_id,
  input  wire logic                        final_box,
  output logic                             item_valid,
  input  wire logic                        item_pop,
  output logic [4*COORD_BITS+gbs_pkg::SCORE_W+gbs_pkg::LABEL_W-1:0] item_box,
  output logic                             item_final
);
  localparam int BOX_W = 4*COORD_BITS + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;
  localparam int PW    = $clog2(gbs_pkg::FIFO_DEPTH);
  localparam int CW    = $clog2(gbs_pkg::FIFO_DEPTH + 1);

  logic [BOX_W:0]  slot [gbs_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full       = (fill == CW'(gbs_pkg::FIFO_DEPTH));
  assign item_valid = (fill != '0);
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;
  assign {item_final, item_box} = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= {final_box, label_id, confidence, bottom_y, right_x, top_y, left_x};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/gbs_overlap.sv]
// Pipelined IoU test without division: inter*65536 > thr*union
`timescale 1ns / 1ps
`default_nettype none
module gbs_overlap #(
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic [4*COORD_BITS-1:0]     box_a,
  input  wire logic [4*COORD_BITS-1:0]     box_b,
  input  wire logic [gbs_pkg::SCORE_W-1:0] threshold,
  output logic                             hit
);
  localparam int C  = COORD_BITS;
  localparam int UW = 2*C + 4;
  localparam int PW = UW + gbs_pkg::SCORE_W + 1;

  logic [C-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  assign {ay2, ax2, ay1, ax1} = box_a;
  assign {by2, bx2, by1, bx1} = box_b;

  logic [C-1:0] ix1, iy1, ix2, iy2;
  assign ix1 = (ax1 > bx1) ? ax1 : bx1;
  assign iy1 = (ay1 > by1) ? ay1 : by1;
  assign ix2 = (ax2 < bx2) ? ax2 : bx2;
  assign iy2 = (ay2 < by2) ? ay2 : by2;

  // stage 1: separation and signed extents
  logic              sep1;
  logic signed [C:0] dx1, dy1, wa1, ha1, wb1, hb1;
  // stage 2: areas
  logic                sep2;
  logic signed [2*C+1:0] inter2, aa2, ab2;
  // stage 3: union
  logic                sep3;
  logic signed [2*C+1:0] inter3;
  logic signed [UW-1:0]  uni3;
  // stage 4: scaled union
  logic                sep4;
  logic signed [2*C+1:0] inter4;
  logic                uni_zero4;
  logic signed [PW-1:0]  prod4;
  logic signed [PW-1:0]  lhs;

  always_ff @(posedge clk) begin
    sep1 <= (ax1 > bx2) || (ax2 < bx1) || (ay1 > by2) || (ay2 < by1);
    dx1  <= $signed({1'b0, ix2}) - $signed({1'b0, ix1});
    dy1  <= $signed({1'b0, iy2}) - $signed({1'b0, iy1});
    wa1  <= $signed({1'b0, ax2}) - $signed({1'b0, ax1});
    ha1  <= $signed({1'b0, ay2}) - $signed({1'b0, ay1});
    wb1  <= $signed({1'b0, bx2}) - $signed({1'b0, bx1});
    hb1  <= $signed({1'b0, by2}) - $signed({1'b0, by1});

    sep2   <= sep1;
    inter2 <= dx1 * dy1;
    aa2    <= wa1 * ha1;
    ab2    <= wb1 * hb1;

    sep3   <= sep2;
    inter3 <= inter2;
    uni3   <= UW'(aa2) + UW'(ab2) - UW'(inter2);

    sep4      <= sep3;
    inter4    <= inter3;
    uni_zero4 <= (uni3 == '0);
    prod4     <= $signed({1'b0, threshold}) * uni3;
  end

  assign lhs = PW'($signed({inter4, 16'h0000}));
  assign hit = !sep4 && !uni_zero4 && (lhs > prod4);
endmodule
`default_nettype wire

[hdl/gbs_back.sv]
// Back end: stores a set, ranks it by score unless presorted, suppresses overlaps, emits kept boxes
`timescale 1ns / 1ps
`default_nettype none
module gbs_back #(
  parameter int MAX_BOXES  = gbs_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gbs_pkg::cfg_t               cfg,
  input  wire logic                        item_valid,
  output logic                             item_pop,
  input  wire logic [4*COORD_BITS+gbs_pkg::SCORE_W+gbs_pkg::LABEL_W-1:0] item_box,
  input  wire logic                        item_final,
  output logic                             out_valid,
  input  wire logic                        out_pop,
  output logic [COORD_BITS-1:0]            out_left,
  output logic [COORD_BITS-1:0]            out_top,
  output logic [COORD_BITS-1:0]            out_right,
  output logic [COORD_BITS-1:0]            out_bottom,
  output logic [gbs_pkg::SCORE_W-1:0]      out_score,
  output logic [gbs_pkg::LABEL_W-1:0]      out_label,
  output logic                             out_eos,
  output logic                             out_ovf
);
  localparam int C     = COORD_BITS;
  localparam int BOX_W = 4*C + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;
  localparam int IW    = $clog2(MAX_BOXES);
  localparam int CW    = $clog2(MAX_BOXES + 1);
  localparam int WW    = $clog2(gbs_pkg::OVL_LAT + 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_SR_A = 4'd1;
  localparam logic [3:0] S_SR_B = 4'd2;
  localparam logic [3:0] S_SR_J = 4'd3;
  localparam logic [3:0] S_SR_C = 4'd4;
  localparam logic [3:0] S_NI_A = 4'd5;
  localparam logic [3:0] S_NI_B = 4'd6;
  localparam logic [3:0] S_NI_C = 4'd7;
  localparam logic [3:0] S_NJ_A = 4'd8;
  localparam logic [3:0] S_NJ_B = 4'd9;
  localparam logic [3:0] S_NJ_C = 4'd10;
  localparam logic [3:0] S_NJ_W = 4'd11;
  localparam logic [3:0] S_EM_A = 4'd12;
  localparam logic [3:0] S_EM_B = 4'd13;
  localparam logic [3:0] S_EM_C = 4'd14;

  logic [3:0]   state;
  logic [CW-1:0] count, n, i, j, rank, kept, emitted;
  logic          ovf;
  logic [WW-1:0] wait_cnt;
  logic [gbs_pkg::SCORE_W-1:0] si;
  logic [4*C-1:0] box_a, box_b;
  logic           supp_j;

  // memory ports
  logic           box_we, box_re, ord_we, ord_re, sup_we, sup_re, sup_wd;
  logic [IW-1:0]  box_wa, box_ra, ord_wa, ord_ra, ord_wd, sup_wa, sup_ra;
  logic [BOX_W-1:0] box_rd;
  logic [IW-1:0]  ord_rd;
  logic           sup_rd;
  logic           hit;

  logic           room, last_i, last_j, rank_inc, can_load;
  logic [gbs_pkg::SCORE_W-1:0] sj;
  logic [CW-1:0]  n_new, rank_sum;

  assign room     = (count < CW'(MAX_BOXES));
  assign n_new    = room ? count + 1'b1 : count;
  assign last_i   = (i == n - 1'b1);
  assign last_j   = (j == n - 1'b1);
  assign sj       = box_rd[4*C +: gbs_pkg::SCORE_W];
  assign rank_inc = (sj > si) || ((sj == si) && (j < i));
  assign rank_sum = rank + CW'(rank_inc);
  assign can_load = !out_valid || out_pop;
  assign item_pop = (state == S_LOAD) && item_valid;

  gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk(clk), .we(box_we), .waddr(box_wa), .wdata(item_box),
    .re(box_re), .raddr(box_ra), .rdata(box_rd)
  );

  gbs_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .re(ord_re), .raddr(ord_ra), .rdata(ord_rd)
  );

  gbs_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_sup_ram (
    .clk(clk), .we(sup_we), .waddr(sup_wa), .wdata(sup_wd),
    .re(sup_re), .raddr(sup_ra), .rdata(sup_rd)
  );

  gbs_overlap #(.COORD_BITS(C)) u_overlap (
    .clk(clk), .box_a(box_a), .box_b(box_b), .threshold(cfg.threshold), .hit(hit)
  );

  always_comb begin
    box_we = 1'b0;  box_wa = count[IW-1:0];
    box_re = 1'b0;  box_ra = ord_rd;
    ord_we = 1'b0;  ord_wa = count[IW-1:0];  ord_wd = count[IW-1:0];
    ord_re = 1'b0;  ord_ra = i[IW-1:0];
    sup_we = 1'b0;  sup_wa = count[IW-1:0];  sup_wd = 1'b0;
    sup_re = 1'b0;  sup_ra = i[IW-1:0];
    case (state)
      S_LOAD: begin
        if (item_valid && room) begin
          box_we = 1'b1;
          ord_we = 1'b1;
          sup_we = 1'b1;
        end
      end
      S_SR_A: begin
        box_re = 1'b1;
        box_ra = i[IW-1:0];
      end
      S_SR_J: begin
        box_re = 1'b1;
        box_ra = j[IW-1:0];
      end
      S_SR_C: begin
        if (last_j) begin
          ord_we = 1'b1;
          ord_wa = rank_sum[IW-1:0];
          ord_wd = i[IW-1:0];
        end
      end
      S_NI_A, S_EM_A: begin
        ord_re = 1'b1;
        sup_re = 1'b1;
      end
      S_NI_B, S_EM_B: begin
        box_re = !sup_rd;
      end
      S_NJ_A: begin
        ord_re = 1'b1;
        sup_re = 1'b1;
        ord_ra = j[IW-1:0];
        sup_ra = j[IW-1:0];
      end
      S_NJ_B: begin
        box_re = 1'b1;
      end
      S_NJ_W: begin
        if (wait_cnt == WW'(gbs_pkg::OVL_LAT) && hit && !supp_j) begin
          sup_we = 1'b1;
          sup_wa = j[IW-1:0];
          sup_wd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EM_C && can_load) begin
      out_left   <= box_rd[0 +: C];
      out_top    <= box_rd[C +: C];
      out_right  <= box_rd[2*C +: C];
      out_bottom <= box_rd[3*C +: C];
      out_score  <= box_rd[4*C +: gbs_pkg::SCORE_W];
      out_label  <= box_rd[4*C+gbs_pkg::SCORE_W +: gbs_pkg::LABEL_W];
      out_eos    <= (emitted + 1'b1 == kept);
      out_ovf    <= ovf;
    end
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EM_C && can_load) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (item_valid) begin
            if (room) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (item_final) begin
              n    <= n_new;
              i    <= '0;
              kept <= '0;
              state <= (cfg.presorted || n_new < CW'(2)) ? S_NI_A : S_SR_A;
            end
          end
        end
        S_SR_A: state <= S_SR_B;
        S_SR_B: begin
          si    <= sj;
          j     <= '0;
          rank  <= '0;
          state <= S_SR_J;
        end
        S_SR_J: state <= S_SR_C;
        S_SR_C: begin
          if (last_j) begin
            if (last_i) begin
              i     <= '0;
              state <= S_NI_A;
            end else begin
              i     <= i + 1'b1;
              state <= S_SR_A;
            end
          end else begin
            rank  <= rank_sum;
            j     <= j + 1'b1;
            state <= S_SR_J;
          end
        end
        S_NI_A: state <= S_NI_B;
        S_NI_B: begin
          if (sup_rd) begin
            if (last_i) begin
              i       <= '0;
              emitted <= '0;
              state   <= S_EM_A;
            end else begin
              i     <= i + 1'b1;
              state <= S_NI_A;
            end
          end else begin
            kept  <= kept + 1'b1;
            state <= S_NI_C;
          end
        end
        S_NI_C: begin
          box_a <= box_rd[4*C-1:0];
          if (last_i) begin
            i       <= '0;
            emitted <= '0;
            state   <= S_EM_A;
          end else begin
            j     <= i + 1'b1;
            state <= S_NJ_A;
          end
        end
        S_NJ_A: state <= S_NJ_B;
        S_NJ_B: begin
          supp_j <= sup_rd;
          state  <= S_NJ_C;
        end
        S_NJ_C: begin
          box_b    <= box_rd[4*C-1:0];
          wait_cnt <= '0;
          state    <= S_NJ_W;
        end
        S_NJ_W: begin
          if (wait_cnt == WW'(gbs_pkg::OVL_LAT)) begin
            if (!last_j) begin
              j     <= j + 1'b1;
              state <= S_NJ_A;
            end else if (last_i) begin
              i       <= '0;
              emitted <= '0;
              state   <= S_EM_A;
            end else begin
              i     <= i + 1'b1;
              state <= S_NI_A;
            end
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        S_EM_A: state <= S_EM_B;
        S_EM_B: begin
          if (!sup_rd) begin
            state <= S_EM_C;
          end else if (last_i) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end else begin
            i     <= i + 1'b1;
            state <= S_EM_A;
          end
        end
        S_EM_C: begin
          if (can_load) begin
            emitted <= emitted + 1'b1;
            if (last_i) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              i     <= i + 1'b1;
              state <= S_EM_A;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/gbs_checker.sv]
// Port-level checker of the box suppression core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_box_suppression_core_defines.svh"
module gbs_checker #(
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        full,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [COORD_BITS-1:0]       kept_left_x,
  input wire logic [gbs_pkg::LABEL_W-1:0] kept_label,
  input wire logic                        end_of_set
);
  // Reset leaves nothing to pop and room to push
  `GBS_ASSERT_NEXT(a_reset_idle, rst, empty && !full, "core not idle after reset")
  // A waiting result holds until taken
  `GBS_ASSERT_NEXT_RUN(a_hold, !empty && !pop, !empty && $stable(kept_left_x) && $stable(kept_label) && $stable(end_of_set), "stalled result changed")
  // Both handshake outputs stay known once out of reset
  `GBS_ASSERT_NEXT_RUN(a_known, 1'b1, !$isunknown(full) && !$isunknown(empty), "handshake unknown")
endmodule

bind greedy_box_suppression_core gbs_checker #(.COORD_BITS(COORD_BITS)) u_gbs_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .kept_left_x(kept_left_x), .kept_label(kept_label), .end_of_set(end_of_set)
);
`default_nettype wire

[test/greedy_box_suppression_core_tb.sv]
// Self-checking testbench of the greedy box suppression core
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_suppression_core_tb;
  localparam int CAP = gbs_pkg::MAX_BOXES_DEF;
  localparam int CW  = gbs_pkg::COORD_BITS_DEF;
  localparam int SW  = gbs_pkg::SCORE_W;
  localparam int LW  = gbs_pkg::LABEL_W;
  localparam int IXW = gbs_pkg::CFG_IDX_W;
  localparam int DW  = gbs_pkg::CFG_DATA_W;

  // one box as it is pushed in
  typedef struct packed {
    logic [CW-1:0] lx, ty, rx, by;
    logic [SW-1:0] conf;
    logic [LW-1:0] lab;
    logic          fin;
  } box_t;

  // one kept box as it leaves the core
  typedef struct packed {
    logic [CW-1:0] lx, ty, rx, by;
    logic [SW-1:0] conf;
    logic [LW-1:0] lab;
    logic          eos;
    logic          ovf;
  } kept_t;

  typedef struct {
    box_t  b;
    bit    typed;
    kept_t k;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  box_t in_box = '0;
  logic cfg_write = 1'b0;
  logic [IXW-1:0] cfg_index = '0;
  logic [DW-1:0]  cfg_data = '0;
  kept_t out_box;

  // typed expectation travels with the box like an extra input
  logic  tag_typed = 1'b0;
  kept_t tag_exp = '0;

  always #5 clk = ~clk;

  greedy_box_suppression_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .left_x(in_box.lx), .top_y(in_box.ty), .right_x(in_box.rx), .bottom_y(in_box.by),
    .confidence(in_box.conf), .label_id(in_box.lab), .final_box(in_box.fin),
    .empty(empty), .pop(pop),
    .kept_left_x(out_box.lx), .kept_top_y(out_box.ty), .kept_right_x(out_box.rx),
    .kept_bottom_y(out_box.by), .kept_confidence(out_box.conf), .kept_label(out_box.lab),
    .end_of_set(out_box.eos), .capacity_overflow(out_box.ovf),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the set store and the registers
  // ---------------------------------------------------------------------------
  box_t           set_store[CAP];
  int             set_count = 0;
  bit             set_dropped = 1'b0;
  logic [15:0]    iou_thr = gbs_pkg::THR_RESET;
  bit             skip_sort = 1'b0;
  kept_t          kept_q[$];
  int             err_count = 0;
  int             send_idle = 0;
  int             recv_stall = 0;

  // corners are taken as signed, so inverted boxes give negative areas
  function automatic bit overlap_suppresses(box_t a, box_t b);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    longint inter, area_a, area_b, uni;
    ax1 = a.lx; ay1 = a.ty; ax2 = a.rx; ay2 = a.by;
    bx1 = b.lx; by1 = b.ty; bx2 = b.rx; by2 = b.by;
    if (ax1 > bx2 || ax2 < bx1 || ay1 > by2 || ay2 < by1) return 1'b0;
    inter = ((ax2 < bx2 ? ax2 : bx2) - (ax1 > bx1 ? ax1 : bx1)) *
            ((ay2 < by2 ? ay2 : by2) - (ay1 > by1 ? ay1 : by1));
    area_a = (ax2 - ax1) * (ay2 - ay1);
    area_b = (bx2 - bx1) * (by2 - by1);
    uni = area_a + area_b - inter;
    if (uni == 0) return 1'b0;
    return inter * 65536 > longint'(iou_thr) * uni;
  endfunction

  // store one box; on the last box of a set, rank, suppress and queue the survivors
  task automatic suppress_set(box_t b, ref kept_t res[$]);
    int order[CAP];
    bit gone[CAP];
    int n, cur, j, kept, done;
    kept_t k;
    res = {};
    if (set_count < CAP) begin
      set_store[set_count] = b;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!b.fin) return;
    n = set_count;
    for (int i = 0; i < n; i++) begin
      order[i] = i;
      gone[i] = 1'b0;
    end
    if (!skip_sort) begin
      // stable insertion sort, highest score first
      for (int i = 1; i < n; i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && set_store[order[j-1]].conf < set_store[cur].conf) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
    end
    kept = 0;
    for (int i = 0; i < n; i++) begin
      if (gone[i]) continue;
      kept++;
      for (int m = i + 1; m < n; m++)
        if (!gone[m] && overlap_suppresses(set_store[order[i]], set_store[order[m]]))
          gone[m] = 1'b1;
    end
    done = 0;
    for (int i = 0; i < n; i++) begin
      if (gone[i]) continue;
      b = set_store[order[i]];
      k = '{b.lx, b.ty, b.rx, b.by, b.conf, b.lab, (done + 1 == kept), set_dropped};
      res = {res, k};
      done++;
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  // predict on every box transfer
  always @(posedge clk) begin
    kept_t res[$];
    if (!rst && push && !full) begin
      suppress_set(in_box, res);
      if (res.size() != 0) begin
        if (tag_typed) kept_q = {kept_q, tag_exp};
        else kept_q = {kept_q, res};
      end
    end
  end

  // check every kept-box transfer against the oldest expectation
  always @(posedge clk) begin
    kept_t want;
    if (!rst && pop && !empty) begin
      if (kept_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected kept box %p", out_box);
      end else begin
        want = kept_q.pop_front();
        if (out_box !== want) begin
          err_count++;
          if (err_count <= 10) $display("kept box mismatch: expected %p, got %p", want, out_box);
        end
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_box(box_t b, bit typed = 1'b0, kept_t k = '0);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_box <= b;
    tag_typed <= typed;
    tag_exp <= k;
    do @(posedge clk); while (full);
  endtask

  task automatic write_reg(logic [IXW-1:0] idx, logic [DW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == gbs_pkg::REG_THRESHOLD) iou_thr = val;
    else skip_sort = val[0];
  endtask

  // drain the queue of kept boxes, then let the core settle
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (kept_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic box_t mk(int lx, int ty, int rx, int by, int conf, int lab, bit fin);
    return '{CW'(lx), CW'(ty), CW'(rx), CW'(by), SW'(conf), LW'(lab), fin};
  endfunction

  // single-box set: the box comes straight back as the last of its set
  function automatic row_t solo(box_t b);
    row_t r;
    r.b = b;
    r.typed = 1'b1;
    r.k = '{b.lx, b.ty, b.rx, b.by, b.conf, b.lab, 1'b1, 1'b0};
    return r;
  endfunction

  function automatic row_t plain(box_t b);
    row_t r;
    r.b = b;
    r.typed = 1'b0;
    r.k = '0;
    return r;
  endfunction

  // mostly clustered, well-formed boxes so that overlaps occur; some wide or inverted
  function automatic box_t rand_box(bit fin);
    int cx, cy, w, h, sel;
    box_t b;
    sel = $urandom_range(99);
    cx = $urandom_range(400);
    cy = $urandom_range(400);
    w = $urandom_range(120);
    h = $urandom_range(120);
    b = mk(cx, cy, cx + w, cy + h, $urandom_range(65535), $urandom_range(255), fin);
    if (sel < 15) begin
      b.lx = CW'($urandom_range(4095)); b.ty = CW'($urandom_range(4095));
      b.rx = CW'($urandom_range(b.lx, 4095)); b.by = CW'($urandom_range(b.ty, 4095));
    end else if (sel < 22) begin
      b.lx = CW'($urandom_range(4095)); b.ty = CW'($urandom_range(4095));
      b.rx = CW'($urandom_range(4095)); b.by = CW'($urandom_range(4095));
    end
    if ($urandom_range(3) == 0) b.conf = SW'(32'h8000 + $urandom_range(2));
    return b;
  endfunction

  row_t dir_rows[$];
  int   sent;
  int   set_len;

  task automatic add_row(row_t r);
    dir_rows = {dir_rows, r};
  endtask

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values
    add_row(solo(mk(0, 0, 0, 0, 0, 0, 1)));
    add_row(solo(mk(4095, 4095, 4095, 4095, 65535, 255, 1)));
    add_row(solo(mk(0, 0, 4095, 4095, 65535, 255, 1)));
    add_row(solo(mk(4095, 4095, 0, 0, 1, 170, 1)));
    // identical boxes, weaker first: the stronger one wins after ranking
    add_row(plain(mk(10, 10, 50, 50, 100, 1, 0)));
    add_row(plain(mk(10, 10, 50, 50, 200, 2, 1)));
    // touching edges overlap with zero area
    add_row(plain(mk(0, 0, 10, 10, 500, 3, 0)));
    add_row(plain(mk(10, 0, 20, 10, 400, 4, 1)));
    // fully separate boxes on each side
    add_row(plain(mk(100, 100, 200, 200, 900, 5, 0)));
    add_row(plain(mk(300, 100, 400, 200, 800, 6, 0)));
    add_row(plain(mk(100, 300, 200, 400, 700, 7, 0)));
    add_row(plain(mk(0, 0, 50, 50, 600, 8, 1)));
    // equal scores keep arrival order
    add_row(plain(mk(0, 0, 100, 100, 1000, 9, 0)));
    add_row(plain(mk(5, 5, 105, 105, 1000, 10, 0)));
    add_row(plain(mk(500, 500, 600, 600, 1000, 11, 1)));
    // degenerate points give a zero union
    add_row(plain(mk(7, 7, 7, 7, 300, 12, 0)));
    add_row(plain(mk(7, 7, 7, 7, 300, 13, 1)));
    // inverted boxes enter the test with negative extents
    add_row(plain(mk(200, 200, 100, 100, 50, 14, 0)));
    add_row(plain(mk(150, 150, 120, 120, 60, 15, 0)));
    add_row(plain(mk(100, 100, 200, 200, 70, 16, 1)));
    foreach (dir_rows[i]) send_box(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].k);
    drain();

    // random part: four phases with distinct settings and idling patterns
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(gbs_pkg::REG_THRESHOLD, DW'(0));
          write_reg(gbs_pkg::REG_PRESORTED, DW'(1));
          send_idle = 0; recv_stall = 0;
        end
        1: begin
          write_reg(gbs_pkg::REG_THRESHOLD, DW'(16'hFFFF));
          write_reg(gbs_pkg::REG_PRESORTED, DW'(0));
          send_idle = 48; recv_stall = 0;
        end
        2: begin
          write_reg(gbs_pkg::REG_THRESHOLD, DW'($urandom_range(65535)));
          write_reg(gbs_pkg::REG_PRESORTED, DW'($urandom_range(1)));
          send_idle = 0; recv_stall = 48;
        end
        default: begin
          write_reg(gbs_pkg::REG_THRESHOLD, gbs_pkg::THR_RESET);
          write_reg(gbs_pkg::REG_PRESORTED, DW'(0));
          send_idle = 10; recv_stall = 10;
        end
      endcase
      // overflow set: the box after a full store and the closing box are dropped
      if (ph == 2) begin
        for (int i = 0; i < CAP + 2; i++) send_box(rand_box(i == CAP + 1));
        sent += CAP + 2;
      end
      while (sent < 16 * (ph + 1) + (ph >= 2 ? CAP + 2 : 0)) begin
        set_len = $urandom_range(1, 6);
        for (int i = 0; i < set_len; i++) send_box(rand_box(i == set_len - 1));
        sent += set_len;
      end
      drain();
    end

    if (err_count == 0 && kept_q.size() == 0) begin
      $display("[greedy_box_suppression_core] OK");
    end else begin
      $display("[greedy_box_suppression_core] ERROR");
    end
    $finish;
  end

  // hard limit on run length
  initial begin
    #5ms;
    $display("[greedy_box_suppression_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
